// File: hw/rtl/bski_pkg.sv
// shared constants for the bit-sliced key index: field widths and mode codes
// no dependencies
package bski_pkg;

    localparam int MODE_W = 3;
    localparam int KEY_W  = 32;
    localparam int ID_W   = 6;
    localparam int CNT_W  = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EQUALS     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CONTAINS   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INTERSECTS = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CHECK      = 3'd5;

endpackage

// File: hw/rtl/bit_sliced_key_index_core.sv
// Bit-sliced key index. Each value id keeps a key word in an on-chip memory
// and a present bit. Insert and remove take one input beat and give one result
// beat, passing through the S_RMW and S_ECHO states; check, the unused modes and
// ids out of range go straight to S_ECHO. Insert and remove read the entry,
// modify it and write it back through the memory's write port. A query
// (equals, contains, intersects) streams the entry memory one entry per cycle
// unless a stalled output holds back a match beat, and gives one beat per
// matching id in ascending order, or one not-found beat.
// One input beat is worked on at a time; o_stall is high until it is done.
// Every result beat carries the live count. Depends on bski_pkg.
module bit_sliced_key_index_core #(
    parameter int NUM_VALUES = 64,
    parameter int KEY_LEN    = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [bski_pkg::MODE_W-1:0] i_mode,
    input  logic [bski_pkg::KEY_W-1:0]  i_query_key,
    input  logic [bski_pkg::ID_W-1:0]   i_value_id,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bski_pkg::ID_W-1:0]   o_match_value,
    output logic                       o_found,
    output logic                       o_last,
    output logic [bski_pkg::CNT_W-1:0]  o_live_count
);
    import bski_pkg::*;

    localparam int KW = (KEY_LEN >= KEY_W) ? KEY_W : KEY_LEN;
    localparam int IW = $clog2(NUM_VALUES);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_VALUES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RMW  = 3'd1;
    localparam logic [2:0] S_ECHO = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [MODE_W-1:0]     r_mode;
    logic [KW-1:0]         r_key;
    logic [ID_W-1:0]       r_id;
    logic                  r_idok;
    logic [IW-1:0]         r_idx, n_idx;
    logic [IW-1:0]         r_pend, n_pend;
    logic                  r_has, n_has;
    logic [NUM_VALUES-1:0] r_present, n_present;
    logic [CNT_W-1:0]      r_count, n_count;

    logic [KW-1:0]         r_mem [NUM_VALUES];
    logic [NUM_VALUES-1:0] r_kval, n_kval;
    logic [KW-1:0]         r_rdata;
    logic                  r_rval;

    logic                  rd_en, wr_en;
    logic [IW-1:0]         rd_addr;
    logic [KW-1:0]         wr_data;

    logic                  r_ovalid;
    logic [ID_W-1:0]       r_oval;
    logic                  r_ofound, r_olast;
    logic [CNT_W-1:0]      r_ocount;

    logic                  emit, e_found, e_last;
    logic [ID_W-1:0]       e_val;

    logic                  accept, out_free, in_idok, hit, was;
    logic [KW-1:0]         entry, anded;
    logic [IW-1:0]         widx;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_ovalid || !i_stall;
    assign in_idok  = ({1'b0, i_value_id} < (ID_W + 1)'(NUM_VALUES));
    assign entry    = r_rval ? r_rdata : '0;
    assign anded    = entry & r_key;
    assign widx     = r_id[IW-1:0];
    assign was      = r_present[widx];

    always_comb begin
        unique case (r_mode)
            MODE_EQUALS:   hit = (entry == r_key);
            MODE_CONTAINS: hit = (anded == r_key);
            default:       hit = (anded != '0);
        endcase
        hit = hit && r_present[r_idx];
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_has     = r_has;
        n_present = r_present;
        n_count   = r_count;
        n_kval    = r_kval;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_data   = '0;
        emit      = 1'b0;
        e_val     = '0;
        e_found   = 1'b0;
        e_last    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode) inside
                        MODE_INSERT, MODE_REMOVE: begin
                            if (in_idok) begin
                                rd_en   = 1'b1;
                                rd_addr = i_value_id[IW-1:0];
                                n_state = S_RMW;
                            end else begin
                                n_state = S_ECHO;
                            end
                        end
                        MODE_EQUALS, MODE_CONTAINS, MODE_INTERSECTS: begin
                            rd_en   = 1'b1;
                            n_idx   = '0;
                            n_has   = 1'b0;
                            n_state = S_SCAN;
                        end
                        default: n_state = S_ECHO;
                    endcase
                end
            end
            S_RMW: begin
                wr_en        = 1'b1;
                n_kval[widx] = 1'b1;
                if (r_mode == MODE_INSERT) begin
                    wr_data         = entry | r_key;
                    n_present[widx] = 1'b1;
                    if (!was) n_count = r_count + 1'b1;
                end else begin
                    wr_data         = entry & ~r_key;
                    n_present[widx] = 1'b0;
                    if (was) n_count = r_count - 1'b1;
                end
                n_state = S_ECHO;
            end
            S_ECHO: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_val   = r_id;
                    e_found = r_idok && was && (r_mode == MODE_INSERT
                              || r_mode == MODE_REMOVE || r_mode == MODE_CHECK);
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(hit && r_has) || out_free) begin
                    if (hit && r_has) begin
                        emit    = 1'b1;
                        e_val   = ID_W'(r_pend);
                        e_found = 1'b1;
                        e_last  = 1'b0;
                    end
                    if (hit) begin
                        n_pend = r_idx;
                        n_has  = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = r_idx + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_val   = r_has ? ID_W'(r_pend) : '0;
                    e_found = r_has;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // entry memory, one port each way, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[widx] <= wr_data;
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rval  <= r_kval[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_count   <= '0;
            r_kval    <= '0;
            r_has     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_count   <= n_count;
            r_kval    <= n_kval;
            r_has     <= n_has;
            if (emit) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pend <= n_pend;
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= i_query_key[KW-1:0];
            r_id   <= i_value_id;
            r_idok <= in_idok;
        end
        if (emit) begin
            r_oval   <= e_val;
            r_ofound <= e_found;
            r_olast  <= e_last;
            r_ocount <= n_count;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_match_value = r_oval;
    assign o_found       = r_ofound;
    assign o_last        = r_olast;
    assign o_live_count  = r_ocount;

endmodule

// File: hw/rtl/bski_chk.sv
// port-level checks for bit_sliced_key_index_core, attached by bind
// depends on bski_pkg and the top level's port list
module bski_chk #(
    parameter int NUM_VALUES = 64
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [bski_pkg::MODE_W-1:0] i_mode,
    input logic [bski_pkg::KEY_W-1:0]  i_query_key,
    input logic [bski_pkg::ID_W-1:0]   i_value_id,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [bski_pkg::ID_W-1:0]   o_match_value,
    input logic                        o_found,
    input logic                        o_last,
    input logic [bski_pkg::CNT_W-1:0]  o_live_count
);
    import bski_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_match_value)
            && $stable(o_found) && $stable(o_last) && $stable(o_live_count))
        else $error("stalled result beat changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again before the previous beat finished");

    a_miss_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last)
        else $error("not-found beat without last");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_live_count <= CNT_W'(NUM_VALUES))
        else $error("live count above the number of values");

endmodule

bind bit_sliced_key_index_core bski_chk #(.NUM_VALUES(NUM_VALUES)) u_bski_chk (.*);
